// ===== sv/tnl_enc_pkg.sv =====
package tnl_enc_pkg;

    // Default send buffer size in bytes
    localparam int BUFFER_SIZE_DEF = 1024;

    // Fixed field widths
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 11;
    localparam int CFG_A_W  = 2;
    localparam int CFG_D_W  = 2;
    localparam int NL_W     = 2;

    // Configuration register indexes
    localparam logic [CFG_A_W-1:0] REG_NEWLINE_MODE  = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_TELNET_ON     = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_TELNET_BINARY = 2'd2;

    // Newline modes
    localparam logic [NL_W-1:0] NL_CR   = 2'd0;
    localparam logic [NL_W-1:0] NL_LF   = 2'd1;
    localparam logic [NL_W-1:0] NL_CRLF = 2'd2;

    // Input commands
    localparam logic CMD_ENCODE  = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // Byte codes
    localparam logic [BYTE_W-1:0] CHR_NUL = 8'h00;
    localparam logic [BYTE_W-1:0] CHR_LF  = 8'h0a;
    localparam logic [BYTE_W-1:0] CHR_CR  = 8'h0d;
    localparam logic [BYTE_W-1:0] CHR_IAC = 8'hff;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               dropped;
        logic               run_last;
        logic               string_end;
        logic [COUNT_W-1:0] fill_after;
    } result_t;

endpackage

// ===== sv/telnet_newline_output_encoder.sv =====
// Telnet newline output encoder.
//
// Input channel (s_*): one word per command. cmd encode places data_byte into
// the send buffer, expanding CR into CR, LF, CR LF or CR NUL per the newline
// mode and doubling 0xFF when telnet is on. cmd release lowers the fill count
// by freed_count (saturating at zero) and produces no result.
// Result channel (m_*): one word per encoded byte, or one word flagged dropped
// when the byte found no room. run_last marks the last word of an input.
// Configuration: write cfg_wdata to register cfg_addr when cfg_we is high;
// the user must write only while the block is idle; the block does not enforce it.
//
// The first result word is registered and valid in the cycle after the input
// is taken. A new input is taken only while the output register is free; for an
// expanding input the second word waits in a holding register that blocks
// s_ready until it moves to the output register.
// Reset clears the fill count, the configuration and both valid flags.
// When the receiver stalls, the output word holds and s_ready stays low until
// that word is taken and no second word is left waiting.
module telnet_newline_output_encoder #(
    parameter int BUFFER_SIZE = tnl_enc_pkg::BUFFER_SIZE_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_we,
    input  logic [tnl_enc_pkg::CFG_A_W-1:0]  cfg_addr,
    input  logic [tnl_enc_pkg::CFG_D_W-1:0]  cfg_wdata,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_cmd,
    input  logic [tnl_enc_pkg::BYTE_W-1:0]   s_data_byte,
    input  logic                             s_final_byte,
    input  logic [tnl_enc_pkg::COUNT_W-1:0]  s_freed_count,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [tnl_enc_pkg::BYTE_W-1:0]   m_out_byte,
    output logic                             m_dropped,
    output logic                             m_run_last,
    output logic                             m_string_end,
    output logic [tnl_enc_pkg::COUNT_W-1:0]  m_fill_after
);

    import tnl_enc_pkg::*;

    // Fill register width, and a compare width that holds the fill, the
    // freed count and the buffer size with a spare bit for increments.
    localparam int FW = $clog2(BUFFER_SIZE + 1);
    localparam int CW = ((FW > COUNT_W) ? FW : COUNT_W) + 1;
    localparam logic [CW-1:0] BUF_EXT = CW'(BUFFER_SIZE);

    logic [FW-1:0]   fill_reg, fill_next;
    logic [NL_W-1:0] newline_mode_reg;
    logic            telnet_on_reg;
    logic            telnet_binary_reg;

    result_t         out_reg, out_next;
    logic            out_valid_reg, out_valid_next;
    result_t         hold_reg, hold_next;
    logic            hold_valid_reg, hold_valid_next;

    logic            out_free;
    logic            accept;

    logic [CW-1:0]   fill_ext, fill1, fill2, freed_ext;
    logic [BYTE_W-1:0] first_byte, second_byte;
    logic            two, iac_drop, full, drop, emit2;
    result_t         res0, res1;

    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = out_free && !hold_valid_reg;
    assign accept   = s_valid && s_ready;

    // Encode the incoming word against the current fill count.
    always_comb begin
        fill_ext  = {{(CW-FW){1'b0}}, fill_reg};
        freed_ext = {{(CW-COUNT_W){1'b0}}, s_freed_count};
        fill1     = fill_ext + CW'(1);
        fill2     = fill_ext + CW'(2);
        full      = fill_ext >= BUF_EXT;

        first_byte  = s_data_byte;
        second_byte = CHR_NUL;
        two         = 1'b0;
        iac_drop    = 1'b0;

        if (s_data_byte == CHR_CR) begin
            case (newline_mode_reg)
                NL_LF: begin
                    first_byte = CHR_LF;
                end
                NL_CR: begin
                    if (telnet_on_reg && !telnet_binary_reg) begin
                        two = 1'b1;
                    end
                end
                default: begin
                    // CR LF, and the unused mode acts the same
                    second_byte = CHR_LF;
                    two         = 1'b1;
                end
            endcase
        end else if (s_data_byte == CHR_IAC && telnet_on_reg) begin
            // Double only with two free slots, else drop the byte
            if (fill1 >= BUF_EXT) begin
                iac_drop = 1'b1;
            end else begin
                second_byte = CHR_IAC;
                two         = 1'b1;
            end
        end

        drop  = full || iac_drop;
        emit2 = two && !drop && (fill1 < BUF_EXT);

        if (drop) begin
            res0.out_byte   = CHR_NUL;
            res0.dropped    = 1'b1;
            res0.run_last   = 1'b1;
            res0.string_end = s_final_byte;
            res0.fill_after = fill_ext[COUNT_W-1:0];
        end else begin
            res0.out_byte   = first_byte;
            res0.dropped    = 1'b0;
            res0.run_last   = !emit2;
            res0.string_end = emit2 ? 1'b0 : s_final_byte;
            res0.fill_after = fill1[COUNT_W-1:0];
        end

        res1.out_byte   = second_byte;
        res1.dropped    = 1'b0;
        res1.run_last   = 1'b1;
        res1.string_end = s_final_byte;
        res1.fill_after = fill2[COUNT_W-1:0];

        // Advance the fill count
        fill_next = fill_reg;
        if (accept) begin
            if (s_cmd == CMD_RELEASE) begin
                fill_next = (freed_ext >= fill_ext) ? '0 : FW'(fill_ext - freed_ext);
            end else if (!drop) begin
                fill_next = emit2 ? FW'(fill2) : FW'(fill1);
            end
        end
    end

    // Output register and second-word holding register
    always_comb begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;

        if (out_free) begin
            if (hold_valid_reg) begin
                // Move the waiting second word up
                out_next        = hold_reg;
                out_valid_next  = 1'b1;
                hold_valid_next = 1'b0;
            end else if (accept && s_cmd == CMD_ENCODE) begin
                out_next        = res0;
                out_valid_next  = 1'b1;
                hold_next       = res1;
                hold_valid_next = emit2;
            end else begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg          <= '0;
            newline_mode_reg  <= NL_CR;
            telnet_on_reg     <= 1'b0;
            telnet_binary_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
            hold_valid_reg    <= 1'b0;
        end else begin
            fill_reg       <= fill_next;
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
            if (cfg_we) begin
                case (cfg_addr)
                    REG_NEWLINE_MODE:  newline_mode_reg  <= cfg_wdata[NL_W-1:0];
                    REG_TELNET_ON:     telnet_on_reg     <= cfg_wdata[0];
                    REG_TELNET_BINARY: telnet_binary_reg <= cfg_wdata[0];
                    default: begin
                        // ignore writes to unmapped indexes
                    end
                endcase
            end
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        hold_reg <= hold_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_out_byte   = out_reg.out_byte;
    assign m_dropped    = out_reg.dropped;
    assign m_run_last   = out_reg.run_last;
    assign m_string_end = out_reg.string_end;
    assign m_fill_after = out_reg.fill_after;

endmodule
